### sv/gifl_pkg.sv
// Shared types and constants for the GIF LZW decoder unit.
// Has no dependencies. The top level uses it through scoped names.
package gifl_pkg;

  // Field widths that the stream format fixes.
  localparam int unsigned CODE_W   = 12;  // widest LZW code
  localparam int unsigned ACC_W    = 19;  // bit accumulator
  localparam int unsigned BITS_W   = 5;   // count of held bits
  localparam int unsigned CW_W     = 4;   // current code width
  localparam int unsigned MCS_W    = 4;   // minimum code size register
  localparam int unsigned DIM_W    = 16;  // image width, height, x and y
  localparam int unsigned PIX_W    = 8;   // palette index
  localparam int unsigned CLR_W    = 9;   // clear code, at most 256
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd2;

  localparam logic [MCS_W-1:0] MCS_RESET = 4'd8;
  localparam logic [MCS_W-1:0] MCS_LOW   = 4'd1;
  localparam logic [MCS_W-1:0] MCS_HIGH  = 4'd8;

  localparam logic [DIM_W-1:0] ROW_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_REFUSED = 3'd2,
    ST_NEED    = 3'd3,
    ST_CLEAR   = 3'd4,
    ST_END     = 3'd5,
    ST_INVALID = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POP  = 5'b00010,
    S_WALK = 5'b00100,
    S_ROOT = 5'b01000,
    S_UPD  = 5'b10000
  } fsm_t;

  typedef struct packed {
    status_t           status;
    logic [PIX_W-1:0]  pixel_index;
    logic [DIM_W-1:0]  pixel_x;
    logic [DIM_W-1:0]  pixel_y;
    logic              inside_image;
  } result_t;

endpackage

### sv/gif_lzw_decoder_unit.sv
// GIF LZW decoder: bit accumulator, code table memories and string stack.
// Depends on gifl_pkg for types and constants.
//
// A feed item, or a pull that yields a status without a pixel, completes in the
// cycle it is accepted. A pull that pops a stacked pixel passes through S_POP
// (stack memory read). A pull that decodes a code walks the string chain through
// the table memories in S_WALK, one entry per cycle, then passes S_ROOT, S_UPD
// and S_POP; every later pixel of that string is popped through S_POP.
// Reset (synchronous, rst_n low) empties the stack, clears the accumulator,
// position and halt flag, and restores the registers to their reset values.
module gif_lzw_decoder_unit #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Item input: feed a byte or pull one result.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [gifl_pkg::PIX_W-1:0]        in_data_byte,
  // Result output.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [gifl_pkg::PIX_W-1:0]        out_pixel_index,
  output logic [gifl_pkg::DIM_W-1:0]        out_pixel_x,
  output logic [gifl_pkg::DIM_W-1:0]        out_pixel_y,
  output logic                              out_inside_image,
  // Configuration write port.
  input  logic                              cfg_wr_en,
  input  logic [gifl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gifl_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  // Table and stack addressing follows the table depth. The count needs one
  // more bit so that it can hold the full depth.
  localparam int unsigned AW    = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = AW + 1;
  localparam int unsigned NC_W  = gifl_pkg::CODE_W + 1;

  localparam logic [CNT_W-1:0]            DEPTH  = CNT_W'(TABLE_ENTRIES);
  localparam logic [NC_W-1:0]             NC_TOP = NC_W'(TABLE_ENTRIES);
  localparam logic [gifl_pkg::CW_W-1:0]   CW_MAX = gifl_pkg::CW_W'(MAX_CODE_BITS);

  // Memories: prefix and suffix halves of the code table, and the string stack.
  logic [AW-1:0]              pfx_mem [TABLE_ENTRIES];
  logic [gifl_pkg::PIX_W-1:0] sfx_mem [TABLE_ENTRIES];
  logic [gifl_pkg::PIX_W-1:0] stk_mem [TABLE_ENTRIES];

  // Configuration registers.
  logic [gifl_pkg::MCS_W-1:0] mcs_r;
  logic [gifl_pkg::DIM_W-1:0] width_r;
  logic [gifl_pkg::DIM_W-1:0] height_r;

  // Decoder state.
  gifl_pkg::fsm_t              state_r, state_nxt;
  logic [gifl_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [gifl_pkg::BITS_W-1:0] bits_r, bits_nxt;
  logic [gifl_pkg::CW_W-1:0]   cw_r, cw_nxt;
  logic [NC_W-1:0]             nc_r, nc_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [gifl_pkg::DIM_W-1:0]  col_r, col_nxt;
  logic [gifl_pkg::DIM_W-1:0]  row_r, row_nxt;
  logic                        halt_r, halt_nxt;
  logic [gifl_pkg::CODE_W-1:0] code_r, code_nxt;   // code being decoded
  logic [gifl_pkg::CODE_W-1:0] link_r, link_nxt;   // current chain position

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  gifl_pkg::result_t           res_r, res_nxt;

  // Memory ports.
  logic [AW-1:0]               tbl_raddr;
  logic [AW-1:0]               pfx_q;
  logic [gifl_pkg::PIX_W-1:0]  sfx_q;
  logic                        pfx_we;
  logic [AW-1:0]               pfx_waddr;
  logic [AW-1:0]               pfx_wdata;
  logic                        sfx_we;
  logic [AW-1:0]               sfx_waddr;
  logic [gifl_pkg::PIX_W-1:0]  sfx_wdata;
  logic                        stk_we;
  logic [AW-1:0]               stk_waddr;
  logic [gifl_pkg::PIX_W-1:0]  stk_wdata;
  logic [AW-1:0]               stk_raddr;
  logic [gifl_pkg::PIX_W-1:0]  stk_q;

  // Derived values.
  logic                        in_take;
  logic                        out_free;
  logic [gifl_pkg::MCS_W-1:0]  eff_min;
  logic [gifl_pkg::CLR_W-1:0]  clear_code;
  logic [gifl_pkg::CODE_W-1:0] clear_ext;
  logic [gifl_pkg::CODE_W-1:0] end_ext;
  logic [gifl_pkg::CODE_W-1:0] code_mask;
  logic [gifl_pkg::CODE_W-1:0] code_now;
  logic [gifl_pkg::CODE_W-1:0] pfx_ext;
  logic [gifl_pkg::DIM_W-1:0]  eff_width;
  logic [gifl_pkg::DIM_W:0]    col_inc;
  logic                        push_en;
  logic [gifl_pkg::PIX_W-1:0]  push_data;

  // The output register is free when empty or drained in this cycle. Items are
  // only taken in the idle state, so a result can always be loaded without
  // overwriting one that still waits.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == gifl_pkg::S_IDLE) && out_free);
  assign in_take  = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_pixel_index  = res_r.pixel_index;
  assign out_pixel_x      = res_r.pixel_x;
  assign out_pixel_y      = res_r.pixel_y;
  assign out_inside_image = res_r.inside_image;

  // Minimum code size is clamped into its legal range before use.
  always_comb begin
    if (mcs_r < gifl_pkg::MCS_LOW) begin
      eff_min = gifl_pkg::MCS_LOW;
    end else if (mcs_r > gifl_pkg::MCS_HIGH) begin
      eff_min = gifl_pkg::MCS_HIGH;
    end else begin
      eff_min = mcs_r;
    end
  end

  assign clear_code = gifl_pkg::CLR_W'(1) << eff_min;
  assign clear_ext  = gifl_pkg::CODE_W'(clear_code);
  assign end_ext    = clear_ext + gifl_pkg::CODE_W'(1);
  assign code_mask  = gifl_pkg::CODE_W'((NC_W'(1) << cw_r) - NC_W'(1));
  assign code_now   = acc_r[gifl_pkg::CODE_W-1:0] & code_mask;
  assign pfx_ext    = gifl_pkg::CODE_W'(pfx_q);

  // A zero width behaves as a width of one. The column is compared one bit
  // wider so that a width lowered mid-stream still wraps.
  assign eff_width = (width_r == '0) ? gifl_pkg::DIM_W'(1) : width_r;
  assign col_inc   = {1'b0, col_r} + (gifl_pkg::DIM_W+1)'(1);

  // The stack is always read just below its top, ready for the next pop.
  assign stk_raddr = AW'(cnt_r - CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    bits_nxt      = bits_r;
    cw_nxt        = cw_r;
    nc_nxt        = nc_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    halt_nxt      = halt_r;
    code_nxt      = code_r;
    link_nxt      = link_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    tbl_raddr     = link_r[AW-1:0];
    pfx_we        = 1'b0;
    pfx_waddr     = nc_r[AW-1:0];
    pfx_wdata     = code_r[AW-1:0];
    sfx_we        = 1'b0;
    sfx_waddr     = nc_r[AW-1:0];
    sfx_wdata     = link_r[gifl_pkg::PIX_W-1:0];
    push_en       = 1'b0;
    push_data     = link_r[gifl_pkg::PIX_W-1:0];

    unique case (state_r)
      gifl_pkg::S_IDLE: begin
        if (in_take) begin
          // Default result: a status with all pixel fields zero.
          res_nxt              = '0;
          out_valid_nxt        = 1'b1;
          if (!in_mode) begin
            if (halt_r || (bits_r >= gifl_pkg::BITS_W'(cw_r))) begin
              res_nxt.status = gifl_pkg::ST_REFUSED;
            end else begin
              acc_nxt  = acc_r | (gifl_pkg::ACC_W'(in_data_byte) << bits_r);
              bits_nxt = bits_r + gifl_pkg::BITS_W'(8);
              res_nxt.status = gifl_pkg::ST_TAKEN;
            end
          end else if (cnt_r != '0) begin
            // Pixel waiting on the stack: pop it; the result is loaded in S_POP.
            out_valid_nxt = 1'b0;
            cnt_nxt       = cnt_r - CNT_W'(1);
            state_nxt     = gifl_pkg::S_POP;
          end else if (halt_r) begin
            res_nxt.status = gifl_pkg::ST_END;
          end else if (bits_r < gifl_pkg::BITS_W'(cw_r)) begin
            res_nxt.status = gifl_pkg::ST_NEED;
          end else begin
            acc_nxt  = acc_r >> cw_r;
            bits_nxt = bits_r - gifl_pkg::BITS_W'(cw_r);
            if (code_now == end_ext) begin
              halt_nxt       = 1'b1;
              res_nxt.status = gifl_pkg::ST_END;
            end else if (code_now == clear_ext) begin
              cw_nxt         = eff_min + gifl_pkg::CW_W'(1);
              nc_nxt         = NC_W'(clear_code) + NC_W'(2);
              res_nxt.status = gifl_pkg::ST_CLEAR;
            end else if (NC_W'(code_now) >= nc_r) begin
              halt_nxt       = 1'b1;
              res_nxt.status = gifl_pkg::ST_INVALID;
            end else begin
              // Start the chain walk; the pixel comes out after it.
              out_valid_nxt = 1'b0;
              code_nxt      = code_now;
              link_nxt      = code_now;
              tbl_raddr     = code_now[AW-1:0];
              if (code_now > clear_ext) begin
                state_nxt = gifl_pkg::S_WALK;
              end else begin
                state_nxt = gifl_pkg::S_ROOT;
              end
            end
          end
        end
      end

      gifl_pkg::S_WALK: begin
        // Table data for the current link is here: stack its suffix and
        // follow its prefix, issuing the next read at once.
        push_en   = 1'b1;
        push_data = sfx_q;
        link_nxt  = pfx_ext;
        tbl_raddr = pfx_q;
        if (pfx_ext <= clear_ext) begin
          state_nxt = gifl_pkg::S_ROOT;
        end
      end

      gifl_pkg::S_ROOT: begin
        // Stack the root and complete the pending suffix of the previous
        // entry; the new entry gets its prefix now.
        push_en   = 1'b1;
        push_data = link_r[gifl_pkg::PIX_W-1:0];
        sfx_we    = (nc_r <= NC_TOP);
        sfx_waddr = AW'(nc_r - NC_W'(1));
        pfx_we    = (nc_r < NC_TOP);
        state_nxt = gifl_pkg::S_UPD;
      end

      gifl_pkg::S_UPD: begin
        // Provisional suffix of the new entry, then grow the table.
        sfx_we = (nc_r < NC_TOP);
        if (nc_r <= NC_TOP) begin
          nc_nxt = nc_r + NC_W'(1);
          if (((nc_r & (NC_W'(1) << cw_r)) != '0) && (cw_r != CW_MAX)) begin
            cw_nxt = cw_r + gifl_pkg::CW_W'(1);
          end
        end
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = gifl_pkg::S_POP;
      end

      gifl_pkg::S_POP: begin
        res_nxt.status       = gifl_pkg::ST_PIXEL;
        res_nxt.pixel_index  = stk_q;
        res_nxt.pixel_x      = col_r;
        res_nxt.pixel_y      = row_r;
        res_nxt.inside_image = (row_r < height_r);
        out_valid_nxt        = 1'b1;
        if (col_inc >= {1'b0, eff_width}) begin
          col_nxt = '0;
          if (row_r != gifl_pkg::ROW_MAX) begin
            row_nxt = row_r + gifl_pkg::DIM_W'(1);
          end
        end else begin
          col_nxt = col_inc[gifl_pkg::DIM_W-1:0];
        end
        state_nxt = gifl_pkg::S_IDLE;
      end

      default: begin
        state_nxt = gifl_pkg::S_IDLE;
      end
    endcase

    // A push past the full depth is dropped.
    if (push_en && (cnt_r < DEPTH)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign stk_we    = push_en && (cnt_r < DEPTH);
  assign stk_waddr = cnt_r[AW-1:0];
  assign stk_wdata = push_data;

  // Synchronous memories with registered read data.
  always_ff @(posedge clk) begin
    if (pfx_we) begin
      pfx_mem[pfx_waddr] <= pfx_wdata;
    end
    if (sfx_we) begin
      sfx_mem[sfx_waddr] <= sfx_wdata;
    end
    pfx_q <= pfx_mem[tbl_raddr];
    sfx_q <= sfx_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcs_r    <= gifl_pkg::MCS_RESET;
      width_r  <= gifl_pkg::DIM_W'(1);
      height_r <= gifl_pkg::DIM_W'(1);
    end else if (cfg_wr_en) begin
      if (cfg_index == gifl_pkg::CFG_MIN_CODE_SIZE) begin
        mcs_r <= cfg_wdata[gifl_pkg::MCS_W-1:0];
      end else if (cfg_index == gifl_pkg::CFG_IMAGE_WIDTH) begin
        width_r <= cfg_wdata;
      end else if (cfg_index == gifl_pkg::CFG_IMAGE_HEIGHT) begin
        height_r <= cfg_wdata;
      end
    end
  end

  // Control state. Reset restores the table to the reset code size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gifl_pkg::S_IDLE;
      acc_r       <= '0;
      bits_r      <= '0;
      cw_r        <= gifl_pkg::MCS_RESET + gifl_pkg::CW_W'(1);
      nc_r        <= (NC_W'(1) << gifl_pkg::MCS_RESET) + NC_W'(2);
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      bits_r      <= bits_nxt;
      cw_r        <= cw_nxt;
      nc_r        <= nc_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    link_r <= link_nxt;
    res_r  <= res_nxt;
  end

endmodule
